/* src/crlp_pkg.sv */
package crlp_pkg;

	localparam int unsigned GROUPS = 8;
	localparam int unsigned CAPS_W = 30;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || ((c >= CH_UA) && (c <= CH_UZ)) ||
			((c >= CH_LA) && (c <= CH_LZ));
	endfunction

	// Clips a group mask to its field width and moves it to its field offset.
	function automatic logic [CAPS_W-1:0] field_bits(input logic [2:0] g,
		input logic [7:0] m);
		logic [CAPS_W-1:0] r;
		r = '0;
		unique case (g)
			3'd0: r = {28'd0, m[1:0]};
			3'd1: r = {22'd0, m[5:0], 2'd0};
			3'd2: r = {17'd0, m[4:0], 8'd0};
			3'd3: r = {14'd0, m[2:0], 13'd0};
			3'd4: r = {10'd0, m[3:0], 16'd0};
			3'd5: r = {10'd0, m[1:0], 18'd0};
			3'd6: r = {8'd0, m[1:0], 20'd0};
			3'd7: r = {m[7:0], 22'd0};
			default: r = '0;
		endcase
		return r;
	endfunction

	// One more decimal digit, saturating at 255.
	function automatic logic [7:0] sat_digit(input logic [7:0] v, input logic [7:0] c);
		logic [11:0] t;
		t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {4'd0, 8'(c - CH_0)};
		return (t > 12'd255) ? 8'hFF : t[7:0];
	endfunction

	function automatic logic [7:0] range_bits(input logic [7:0] lo, input logic [7:0] hi);
		logic [7:0] r;
		for (int b = 0; b < 8; b++) begin
			r[b] = (8'(b) >= lo) && (8'(b) <= hi);
		end
		return r;
	endfunction

endpackage

/* src/capability_range_list_parser.sv */
// A terminating zero word passes through the input register (ch_s1) and then
// sets the registered result, ok and caps_valid.
// Throughput: one text word per cycle unless ch_stall holds it; each word is
// parsed combinationally, in at most three feed_step passes, between the input register and the parser state register.
// A result waiting at the output stalls the input only when the next word is
// also a terminator. Reset (arst_n low) clears the parser state and both valids.
module capability_range_list_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    ch,
	input  logic                          ch_valid,
	output logic                          ch_stall,
	output logic [crlp_pkg::CAPS_W-1:0]   packed_caps,
	output logic                          ok,
	output logic                          caps_valid,
	input  logic                          caps_stall
);

	typedef enum logic [3:0] {
		PH_AWAIT,
		PH_GROUP,
		PH_NUM,
		PH_WORD,
		PH_DASH,
		PH_HIGH,
		PH_DOT,
		PH_AFTER_CLOSE,
		PH_IGNORE
	} phase_t;

	typedef struct packed {
		phase_t                        phase;
		logic [3:0]                    gidx;
		logic [7:0]                    mask;
		logic [7:0]                    lo;
		logic [7:0]                    hi;
		logic                          word;
		logic                          paren;
		logic                          list;
		logic [crlp_pkg::CAPS_W-1:0]   acc;
		logic                          failed;
	} pstate_t;

	typedef struct packed {
		pstate_t st;
		logic    again;
	} step_t;

	localparam pstate_t ST_RESET = '{phase: PH_AWAIT, default: '0};
	localparam int unsigned PASSES = 3;

	// Closes an item: ORs its range into the group mask unless it is a word, and returns to the group.
	// The byte is looked at again unless it is a list comma.
	function automatic step_t after_item(input pstate_t s, input logic [7:0] lo,
		input logic [7:0] hi, input logic word, input logic [7:0] c);
		step_t r;
		r.st = s;
		if (!word) begin
			r.st.mask = s.mask | crlp_pkg::range_bits(lo, hi);
		end
		r.st.phase = PH_GROUP;
		r.again = !(s.list && (c == crlp_pkg::CH_COMMA));
		return r;
	endfunction

	function automatic step_t feed_step(input pstate_t s, input logic [7:0] c);
		step_t      r;
		logic [3:0] gnew;
		logic [7:0] close_ch;
		logic [7:0] lo_n;
		r.st = s;
		r.again = 1'b0;
		gnew = s.gidx + 4'd1;
		close_ch = s.paren ? crlp_pkg::CH_RPAREN : crlp_pkg::CH_COMMA;
		lo_n = s.word ? 8'd0 : ((s.lo != 8'hFF) ? s.lo + 8'd1 : s.lo);
		unique case (s.phase)
			PH_AWAIT: begin
				if (c != crlp_pkg::CH_SPACE) begin
					r.st.mask = '0;
					if (c == crlp_pkg::CH_LPAREN) begin
						r.st.paren = 1'b1;
						r.st.list = 1'b1;
						r.st.phase = PH_GROUP;
					end else if (crlp_pkg::is_alnum(c)) begin
						r.st.paren = 1'b0;
						r.st.list = (s.gidx == 4'(crlp_pkg::GROUPS - 1));
						r.st.phase = PH_GROUP;
						r.again = 1'b1;
					end else begin
						r.st.failed = 1'b1;
						r.st.phase = PH_IGNORE;
					end
				end
			end
			PH_GROUP: begin
				if ((c == crlp_pkg::CH_NUL) || (c == close_ch)) begin
					r.st.acc = s.acc | crlp_pkg::field_bits(s.gidx[2:0], s.mask);
					r.st.gidx = gnew;
					if (gnew >= 4'(crlp_pkg::GROUPS)) begin
						r.st.phase = PH_IGNORE;
					end else if (c == crlp_pkg::CH_NUL) begin
						r.st.failed = 1'b1;
						r.st.phase = PH_IGNORE;
					end else if (s.paren) begin
						r.st.phase = PH_AFTER_CLOSE;
					end else begin
						r.st.phase = PH_AWAIT;
					end
				end else if (c == crlp_pkg::CH_SPACE) begin
					r.st.phase = PH_GROUP;
				end else if (!crlp_pkg::is_alnum(c)) begin
					r.st.failed = 1'b1;
					r.st.phase = PH_IGNORE;
				end else if (crlp_pkg::is_digit(c)) begin
					r.st.lo = 8'(c - crlp_pkg::CH_0);
					r.st.word = 1'b0;
					r.st.phase = PH_NUM;
				end else begin
					r.st.lo = '0;
					r.st.word = 1'b1;
					r.st.phase = PH_WORD;
				end
			end
			PH_NUM, PH_WORD: begin
				if ((s.phase == PH_NUM) && crlp_pkg::is_digit(c)) begin
					r.st.lo = crlp_pkg::sat_digit(s.lo, c);
				end else if ((s.phase == PH_WORD) && crlp_pkg::is_alnum(c)) begin
					r.st.phase = PH_WORD;
				end else if (c == crlp_pkg::CH_DASH) begin
					r.st.phase = PH_DASH;
				end else if (c == crlp_pkg::CH_DOT) begin
					r.st.phase = PH_DOT;
				end else begin
					r.st.hi = s.lo;
					r = after_item(r.st, s.lo, s.lo, s.word, c);
				end
			end
			PH_DASH: begin
				if (crlp_pkg::is_digit(c)) begin
					r.st.hi = 8'(c - crlp_pkg::CH_0);
					r.st.phase = PH_HIGH;
				end else begin
					r.st.failed = 1'b1;
					r.st.phase = PH_IGNORE;
				end
			end
			PH_HIGH: begin
				if (crlp_pkg::is_digit(c)) begin
					r.st.hi = crlp_pkg::sat_digit(s.hi, c);
				end else begin
					r = after_item(s, s.lo, s.hi, s.word, c);
				end
			end
			PH_DOT: begin
				if (!crlp_pkg::is_digit(c)) begin
					// A word before the dot counts as zero; a number goes up by one.
					r.st.word = 1'b0;
					r.st.lo = lo_n;
					r.st.hi = lo_n;
					r = after_item(r.st, lo_n, lo_n, 1'b0, c);
				end
			end
			PH_AFTER_CLOSE: begin
				r.st.phase = PH_AWAIT;
				r.again = (c != crlp_pkg::CH_COMMA);
			end
			default: begin
				r.st = s;
			end
		endcase
		return r;
	endfunction

	logic       valid_s1;
	logic [7:0] ch_s1;
	pstate_t    st_q;
	pstate_t    st_n;
	logic       fire;
	logic       ok_n;

	// A byte goes through at most three passes (close, await, item start).
	always_comb begin
		step_t r;
		r.st = st_q;
		r.again = 1'b1;
		for (int i = 0; i < PASSES; i++) begin
			if (r.again) begin
				r = feed_step(r.st, ch_s1);
			end
		end
		st_n = r.st;
	end

	assign ok_n = (st_n.phase == PH_IGNORE) && !st_n.failed;
	assign fire = valid_s1 && ((ch_s1 != crlp_pkg::CH_NUL) || !caps_valid || !caps_stall);
	assign ch_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ch_s1 <= '0;
			caps_valid <= 1'b0;
			packed_caps <= '0;
			ok <= 1'b0;
			st_q <= ST_RESET;
		end else begin
			if (!ch_stall) begin
				valid_s1 <= ch_valid;
				if (ch_valid) begin
					ch_s1 <= ch;
				end
			end
			if (fire && (ch_s1 == crlp_pkg::CH_NUL)) begin
				caps_valid <= 1'b1;
			end else if (!caps_stall) begin
				caps_valid <= 1'b0;
			end
			if (fire) begin
				if (ch_s1 == crlp_pkg::CH_NUL) begin
					st_q <= ST_RESET;
					packed_caps <= ok_n ? st_n.acc : '0;
					ok <= ok_n;
				end else begin
					st_q <= st_n;
				end
			end
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		caps_valid && !ok |-> packed_caps == '0)
		else $error("failed result carries nonzero caps");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(caps_valid) |-> $past(valid_s1 && (ch_s1 == crlp_pkg::CH_NUL)))
		else $error("result without a terminator word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		ch_stall |-> valid_s1 && (ch_s1 == crlp_pkg::CH_NUL) && caps_valid && caps_stall)
		else $error("input stalled without a blocked result");

	a_gidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.gidx <= 4'(crlp_pkg::GROUPS))
		else $error("group index beyond group count");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_IGNORE) && !st_q.failed |-> st_q.gidx == 4'(crlp_pkg::GROUPS))
		else $error("parse finished before all groups");

endmodule
